// ===== src/jssc_pkg.sv =====
// jssc_pkg: constants, result type and signature lookup for the jpeg segment checker
// no dependencies; used by the interfaces-facing top level and the parser
`timescale 1ns / 1ps

package jssc_pkg;

  localparam int unsigned CountBitsDef = 32;
  localparam int unsigned RptCountBits = 32;

  localparam logic [15:0] LimitReset = 16'd2048;

  localparam logic [7:0] FillByte   = 8'hFF;
  localparam logic [7:0] StuffByte  = 8'h00;
  localparam logic [7:0] MarkerSoi  = 8'hD8;
  localparam logic [7:0] MarkerEoi  = 8'hD9;
  localparam logic [7:0] RstFirst   = 8'hD0;
  localparam logic [7:0] RstLast    = 8'hD7;
  localparam logic [7:0] AppFirst   = 8'hE0;
  localparam logic [7:0] AppLast    = 8'hEF;
  localparam logic [7:0] MarkerApp1 = 8'hE1;
  localparam logic [7:0] MarkerCom  = 8'hFE;

  localparam logic [2:0] ExifSigLen = 3'd6;
  localparam logic [15:0] ExifMinLen = 16'd8;
  localparam logic [15:0] LenHdrBytes = 16'd2;

  typedef struct packed {
    logic                    bad_header;
    logic                    big_text_segment;
    logic                    bad_exif;
    logic                    trailing_data;
    logic [RptCountBits-1:0] trailing_count;
    logic                    anomaly;
  } rpt_t;

  // "Exif" followed by two zero bytes
  function automatic logic [7:0] exif_sig_byte(input logic [2:0] idx);
    logic [7:0] res;
    case (idx)
      3'd0:    res = 8'h45;
      3'd1:    res = 8'h78;
      3'd2:    res = 8'h69;
      3'd3:    res = 8'h66;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

// ===== src/jssc_if.sv =====
// jssc channel interfaces: byte input, limit write and report output
// valid/ready handshake; payload widths follow jssc_pkg result layout
`timescale 1ns / 1ps

interface jssc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source(output valid, byte_value, last_byte, input ready);
  modport sink(input valid, byte_value, last_byte, output ready);
endinterface

interface jssc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] text_segment_limit;

  modport source(output valid, text_segment_limit, input ready);
  modport sink(input valid, text_segment_limit, output ready);
endinterface

interface jssc_rpt_if;
  logic        valid;
  logic        ready;
  logic        bad_header;
  logic        big_text_segment;
  logic        bad_exif;
  logic        trailing_data;
  logic [31:0] trailing_count;
  logic        anomaly;

  modport source(output valid, bad_header, big_text_segment, bad_exif, trailing_data,
                 trailing_count, anomaly, input ready);
  modport sink(input valid, bad_header, big_text_segment, bad_exif, trailing_data,
               trailing_count, anomaly, output ready);
endinterface

// ===== src/jpeg_segment_structure_checker.sv =====
// jpeg_segment_structure_checker: top level, limit register and report register
// depends on jssc_pkg, jssc_if interfaces and jssc_parser
//
//   channel  dir  handshake       payload
//   byte_i   in   valid/ready     byte_value[7:0], last_byte
//   cfg_i    in   valid/ready     text_segment_limit[15:0]
//   rpt_o    out  valid/ready     flags, trailing_count[31:0], anomaly
//
// one byte per cycle; the parser state updates in the accepting cycle
// a report appears in the cycle after its last byte is taken, held in one output register
// byte_i stalls only while that register is full and rpt_o.ready is low
// cfg_i is always ready; reset sets the limit to 2048 and rearms the parser
`timescale 1ns / 1ps

module jpeg_segment_structure_checker import jssc_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  jssc_byte_if.sink  byte_i,
  jssc_cfg_if.sink   cfg_i,
  jssc_rpt_if.source rpt_o
);

  logic [15:0] limit_q;
  logic        out_valid_q;
  rpt_t        rpt_q;
  rpt_t        rpt_d;
  logic        take;

  assign byte_i.ready = !out_valid_q || rpt_o.ready;
  assign cfg_i.ready  = 1'b1;
  assign take         = byte_i.valid && byte_i.ready;

  jssc_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_value_i(byte_i.byte_value),
    .last_byte_i (byte_i.last_byte),
    .limit_i     (limit_q),
    .rpt_o       (rpt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      limit_q <= cfg_i.text_segment_limit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && byte_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (rpt_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && byte_i.last_byte) begin
      rpt_q <= rpt_d;
    end
  end

  assign rpt_o.valid            = out_valid_q;
  assign rpt_o.bad_header       = rpt_q.bad_header;
  assign rpt_o.big_text_segment = rpt_q.big_text_segment;
  assign rpt_o.bad_exif         = rpt_q.bad_exif;
  assign rpt_o.trailing_data    = rpt_q.trailing_data;
  assign rpt_o.trailing_count   = rpt_q.trailing_count;
  assign rpt_o.anomaly          = rpt_q.anomaly;

`ifndef ASSERT_OFF
  a_report_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(take && byte_i.last_byte))
    else $error("report raised without a last byte");

  a_anomaly_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> rpt_q.anomaly == (rpt_q.bad_header || rpt_q.big_text_segment ||
                                      rpt_q.bad_exif || rpt_q.trailing_data))
    else $error("anomaly does not match flags");

  a_trail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> rpt_q.trailing_data == (rpt_q.trailing_count != '0))
    else $error("trailing flag and count disagree");

  a_header_no_trail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(rpt_q.bad_header && rpt_q.trailing_data))
    else $error("bad header with trailing data");
`endif

endmodule

// ===== src/jssc_parser.sv =====
// jssc_parser: marker/segment state machine, one byte per accepted item
// depends on jssc_pkg; gives the report for the current byte combinationally
`timescale 1ns / 1ps

module jssc_parser import jssc_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  input  logic [15:0] limit_i,
  output rpt_t        rpt_o
);

  typedef enum logic [3:0] {
    ModeSoiFirst,
    ModeSoiSecond,
    ModeScan,
    ModeMarker,
    ModeLenHigh,
    ModeLenLow,
    ModeBody,
    ModeTrail,
    ModeHalt
  } mode_e;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  mode_e                 mode_q, mode_d;
  logic [7:0]            marker_q, marker_d;
  logic [7:0]            len_hi_q, len_hi_d;
  logic [15:0]           skip_q, skip_d;
  logic [2:0]            exif_idx_q, exif_idx_d;
  logic                  exif_ok_q, exif_ok_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  hdr_q, hdr_d;
  logic                  big_q, big_d;
  logic                  exif_q, exif_d;
  logic                  trail_q, trail_d;

  logic [15:0]             seg_len;
  logic                    is_text;
  logic                    hdr_fin;
  logic [RptCountBits-1:0] cnt_rpt;

  assign seg_len = {len_hi_q, byte_value_i};
  assign is_text = (marker_q inside {[AppFirst:AppLast]}) || (marker_q == MarkerCom);

  always_comb begin
    mode_d     = mode_q;
    marker_d   = marker_q;
    len_hi_d   = len_hi_q;
    skip_d     = skip_q;
    exif_idx_d = exif_idx_q;
    exif_ok_d  = exif_ok_q;
    cnt_d      = cnt_q;
    hdr_d      = hdr_q;
    big_d      = big_q;
    exif_d     = exif_q;
    trail_d    = trail_q;
    case (mode_q)
      ModeSoiFirst: begin
        if (byte_value_i == FillByte) begin
          mode_d = ModeSoiSecond;
        end else begin
          hdr_d  = 1'b1;
          mode_d = ModeHalt;
        end
      end
      ModeSoiSecond: begin
        if (byte_value_i == MarkerSoi) begin
          mode_d = ModeScan;
        end else begin
          hdr_d  = 1'b1;
          mode_d = ModeHalt;
        end
      end
      ModeScan: begin
        if (byte_value_i == FillByte) begin
          mode_d = ModeMarker;
        end
      end
      ModeMarker: begin
        if (byte_value_i == FillByte) begin
          mode_d = ModeMarker;
        end else if (byte_value_i == StuffByte ||
                     (byte_value_i inside {[RstFirst:RstLast]})) begin
          mode_d = ModeScan;
        end else if (byte_value_i == MarkerEoi) begin
          mode_d = ModeTrail;
        end else begin
          marker_d = byte_value_i;
          mode_d   = ModeLenHigh;
        end
      end
      ModeLenHigh: begin
        len_hi_d = byte_value_i;
        mode_d   = ModeLenLow;
      end
      ModeLenLow: begin
        if (is_text && seg_len > limit_i) begin
          big_d = 1'b1;
        end
        if (seg_len < LenHdrBytes) begin
          mode_d = ModeHalt;
        end else begin
          if (marker_q == MarkerApp1) begin
            exif_idx_d = '0;
            exif_ok_d  = 1'b1;
            if (seg_len < ExifMinLen) begin
              exif_d = 1'b1;
            end
          end
          skip_d = seg_len - LenHdrBytes;
          mode_d = (seg_len == LenHdrBytes) ? ModeScan : ModeBody;
        end
      end
      ModeBody: begin
        if (marker_q == MarkerApp1 && exif_idx_q < ExifSigLen) begin
          if (byte_value_i != exif_sig_byte(exif_idx_q)) begin
            if (exif_ok_q) begin
              exif_d = 1'b1;
            end
            exif_ok_d = 1'b0;
          end
          exif_idx_d = exif_idx_q + 3'd1;
        end
        skip_d = skip_q - 16'd1;
        if (skip_q == 16'd1) begin
          mode_d = ModeScan;
        end
      end
      ModeTrail: begin
        if (cnt_q != CountMax) begin
          cnt_d = cnt_q + 1'b1;
        end
        trail_d = 1'b1;
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  // a file that ends right after its first byte still lacks the soi marker
  assign hdr_fin = hdr_d || (mode_d == ModeSoiSecond);

  if (COUNT_BITS > RptCountBits) begin : g_cnt_wide
    assign cnt_rpt = (|cnt_d[COUNT_BITS-1:RptCountBits]) ? '1 : cnt_d[RptCountBits-1:0];
  end else if (COUNT_BITS == RptCountBits) begin : g_cnt_equal
    assign cnt_rpt = cnt_d;
  end else begin : g_cnt_narrow
    assign cnt_rpt = {{(RptCountBits-COUNT_BITS){1'b0}}, cnt_d};
  end

  always_comb begin
    rpt_o.bad_header       = hdr_fin;
    rpt_o.big_text_segment = big_d;
    rpt_o.bad_exif         = exif_d;
    rpt_o.trailing_data    = trail_d;
    rpt_o.trailing_count   = cnt_rpt;
    rpt_o.anomaly          = hdr_fin | big_d | exif_d | trail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeSoiFirst;
      marker_q   <= '0;
      len_hi_q   <= '0;
      skip_q     <= '0;
      exif_idx_q <= '0;
      exif_ok_q  <= 1'b1;
      cnt_q      <= '0;
      hdr_q      <= 1'b0;
      big_q      <= 1'b0;
      exif_q     <= 1'b0;
      trail_q    <= 1'b0;
    end else if (take_i) begin
      if (last_byte_i) begin
        mode_q     <= ModeSoiFirst;
        marker_q   <= '0;
        len_hi_q   <= '0;
        skip_q     <= '0;
        exif_idx_q <= '0;
        exif_ok_q  <= 1'b1;
        cnt_q      <= '0;
        hdr_q      <= 1'b0;
        big_q      <= 1'b0;
        exif_q     <= 1'b0;
        trail_q    <= 1'b0;
      end else begin
        mode_q     <= mode_d;
        marker_q   <= marker_d;
        len_hi_q   <= len_hi_d;
        skip_q     <= skip_d;
        exif_idx_q <= exif_idx_d;
        exif_ok_q  <= exif_ok_d;
        cnt_q      <= cnt_d;
        hdr_q      <= hdr_d;
        big_q      <= big_d;
        exif_q     <= exif_d;
        trail_q    <= trail_d;
      end
    end
  end

`ifndef ASSERT_OFF
  a_body_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeBody |-> skip_q != 16'd0)
    else $error("body state with no bytes left");

  a_exif_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exif_idx_q <= ExifSigLen)
    else $error("exif index past signature");

  a_exif_mismatch_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exif_ok_q |-> exif_q)
    else $error("exif mismatch without flag");
`endif

endmodule

// ===== tb/testbench.sv =====
// testbench for jpeg_segment_structure_checker: directed table then random jpeg-like files
// over several segment limits; a behavioral parser predicts each report unless the table row gives it
// depends on jssc_pkg, the jssc_if interfaces and the checker rtl
`timescale 1ns / 1ps

module testbench;
  import jssc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DirCount = 25;
  localparam logic [7:0] ExifHdr [6] = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};

  typedef enum logic [3:0] {
    PmSoiFirst, PmSoiSecond, PmScan, PmMarker, PmLenHigh, PmLenLow, PmBody, PmTrail, PmHalt
  } parse_mode_e;

  // flags are {bad_header, big_text_segment, bad_exif, trailing_data}
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       typed;
    logic [3:0] flags;
    logic [7:0] count;
  } dir_row_t;

  localparam dir_row_t DirRows [DirCount] = '{
    '{8'h00, 1'b1, 1'b1, 4'b1000, 8'd0},
    '{8'hFF, 1'b1, 1'b1, 4'b1000, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hD8, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hD0, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'h00, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hFE, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'h00, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'h01, 1'b1, 1'b0, 4'b0000, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hD8, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hE1, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'h00, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'h04, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'h45, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'h78, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hD9, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'h00, 1'b0, 1'b0, 4'b0000, 8'd0},
    '{8'hFF, 1'b1, 1'b1, 4'b0011, 8'd2}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  jssc_byte_if byte_if();
  jssc_cfg_if  cfg_if();
  jssc_rpt_if  rpt_if();

  jpeg_segment_structure_checker i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .byte_i(byte_if),
    .cfg_i (cfg_if),
    .rpt_o (rpt_if)
  );

  always #5 clk_i = ~clk_i;

  // parser mirror
  parse_mode_e pmode;
  logic [7:0]  seg_marker;
  logic [7:0]  len_msb;
  logic [15:0] body_left;
  logic [2:0]  sig_pos;
  logic        sig_ok;
  logic [31:0] trail_bytes;
  logic        fl_header, fl_big, fl_exif, fl_trail;
  logic [15:0] limit_q;

  rpt_t        pending_reports[$];
  logic [7:0]  file_bytes[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          pend_typed = 1'b0;
  rpt_t        pend_want = '0;
  bit          hold_off_req = 1'b0;

  task automatic rearm_parser();
    pmode = PmSoiFirst;
    seg_marker = '0;
    len_msb = '0;
    body_left = '0;
    sig_pos = '0;
    sig_ok = 1'b1;
    trail_bytes = '0;
    {fl_header, fl_big, fl_exif, fl_trail} = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last, output bit made,
                            output rpt_t res);
    logic [15:0] seg_len;
    made = 1'b0;
    res = '0;
    case (pmode)
      PmSoiFirst: begin
        if (b == FillByte) pmode = PmSoiSecond;
        else begin
          fl_header = 1'b1;
          pmode = PmHalt;
        end
      end
      PmSoiSecond: begin
        if (b == MarkerSoi) pmode = PmScan;
        else begin
          fl_header = 1'b1;
          pmode = PmHalt;
        end
      end
      PmScan: begin
        if (b == FillByte) pmode = PmMarker;
      end
      PmMarker: begin
        if (b == StuffByte || (b >= RstFirst && b <= RstLast)) pmode = PmScan;
        else if (b == MarkerEoi) pmode = PmTrail;
        else if (b != FillByte) begin
          seg_marker = b;
          pmode = PmLenHigh;
        end
      end
      PmLenHigh: begin
        len_msb = b;
        pmode = PmLenLow;
      end
      PmLenLow: begin
        seg_len = {len_msb, b};
        if (((seg_marker >= AppFirst && seg_marker <= AppLast) || seg_marker == MarkerCom)
            && seg_len > limit_q) fl_big = 1'b1;
        if (seg_len < LenHdrBytes) pmode = PmHalt;
        else begin
          if (seg_marker == MarkerApp1) begin
            sig_pos = '0;
            sig_ok = 1'b1;
            if (seg_len < ExifMinLen) fl_exif = 1'b1;
          end
          body_left = seg_len - LenHdrBytes;
          pmode = (body_left == 0) ? PmScan : PmBody;
        end
      end
      PmBody: begin
        if (seg_marker == MarkerApp1 && sig_pos < ExifSigLen) begin
          if (b != ExifHdr[sig_pos]) begin
            if (sig_ok) fl_exif = 1'b1;
            sig_ok = 1'b0;
          end
          sig_pos++;
        end
        body_left--;
        if (body_left == 0) pmode = PmScan;
      end
      PmTrail: begin
        if (trail_bytes != '1) trail_bytes++;
        fl_trail = 1'b1;
      end
      default: ;
    endcase
    if (last) begin
      if (pmode == PmSoiSecond) fl_header = 1'b1;
      made = 1'b1;
      res.bad_header = fl_header;
      res.big_text_segment = fl_big;
      res.bad_exif = fl_exif;
      res.trailing_data = fl_trail;
      res.trailing_count = trail_bytes;
      res.anomaly = fl_header | fl_big | fl_exif | fl_trail;
      rearm_parser();
    end
  endtask

  always @(posedge clk_i) begin : watch
    rpt_t want;
    bit   made;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        parse_byte(byte_if.byte_value, byte_if.last_byte, made, want);
        if (made) begin
          if (pend_typed) want = pend_want;
          pending_reports = {pending_reports, want};
        end
      end
      if (rpt_if.valid && rpt_if.ready) begin
        if (pending_reports.size() == 0) begin
          $error("report with nothing outstanding");
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (rpt_if.bad_header !== want.bad_header) begin
            $error("bad_header: expected %0d, got %0d", want.bad_header, rpt_if.bad_header);
            mismatches++;
          end
          if (rpt_if.big_text_segment !== want.big_text_segment) begin
            $error("big_text_segment: expected %0d, got %0d", want.big_text_segment,
                   rpt_if.big_text_segment);
            mismatches++;
          end
          if (rpt_if.bad_exif !== want.bad_exif) begin
            $error("bad_exif: expected %0d, got %0d", want.bad_exif, rpt_if.bad_exif);
            mismatches++;
          end
          if (rpt_if.trailing_data !== want.trailing_data) begin
            $error("trailing_data: expected %0d, got %0d", want.trailing_data,
                   rpt_if.trailing_data);
            mismatches++;
          end
          if (rpt_if.trailing_count !== want.trailing_count) begin
            $error("trailing_count: expected %0d, got %0d", want.trailing_count,
                   rpt_if.trailing_count);
            mismatches++;
          end
          if (rpt_if.anomaly !== want.anomaly) begin
            $error("anomaly: expected %0d, got %0d", want.anomaly, rpt_if.anomaly);
            mismatches++;
          end
        end
      end
    end
  end

  // report side stalls in styles that are re-picked at random
  initial begin : rpt_stall
    int unsigned span;
    int unsigned style;
    int unsigned hold_left;
    rpt_if.ready = 1'b0;
    span = 0;
    style = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = 400;
      end
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
      end
      span--;
      if (hold_left != 0) begin
        hold_left--;
        rpt_if.ready <= 1'b0;
      end else begin
        case (style)
          0: rpt_if.ready <= 1'b1;
          1: rpt_if.ready <= 1'($urandom_range(0, 1));
          2: rpt_if.ready <= ($urandom_range(0, 3) == 0);
          default: rpt_if.ready <= (span % 3 != 0);
        endcase
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last, input bit typed,
                          input rpt_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      byte_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pend_typed = typed;
    pend_want = want;
    byte_if.valid <= 1'b1;
    byte_if.byte_value <= b;
    byte_if.last_byte <= last;
    do @(posedge clk_i); while (!byte_if.ready);
    burst_left--;
  endtask

  // sender idle until every report is in, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    byte_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.text_segment_limit <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    limit_q = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic append_byte(input logic [7:0] v);
    file_bytes = {file_bytes, v};
  endtask

  task automatic build_file();
    int unsigned nseg, n, keep, cpos;
    logic [15:0] seg_len;
    logic [7:0]  m, v;
    bit          cut, corrupt;
    file_bytes.delete();
    cut = 1'b0;
    case ($urandom_range(0, 19))
      0: append_byte(8'($urandom_range(0, 255)));
      1: begin
        append_byte(FillByte);
        append_byte(8'($urandom_range(0, 255)));
      end
      2: begin
        append_byte(8'($urandom_range(0, 255)));
        append_byte(MarkerSoi);
      end
      default: begin
        append_byte(FillByte);
        append_byte(MarkerSoi);
      end
    endcase
    nseg = $urandom_range(0, 5);
    for (int s = 0; s < nseg && !cut; s++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // exif segment, sometimes short or with a wrong header byte
          seg_len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 9))
                                                 : 16'($urandom_range(8, 16));
          corrupt = ($urandom_range(0, 2) == 0);
          cpos = $urandom_range(0, 5);
          append_byte(FillByte);
          append_byte(MarkerApp1);
          append_byte(seg_len[15:8]);
          append_byte(seg_len[7:0]);
          for (int j = 0; j + 2 < int'(seg_len); j++) begin
            v = (j < 6) ? ExifHdr[j] : 8'($urandom_range(0, 255));
            if (corrupt && j == int'(cpos)) v = v ^ 8'($urandom_range(1, 255));
            append_byte(v);
          end
        end
        2, 3, 4: begin
          if ($urandom_range(0, 2) == 0) m = 8'($urandom_range(8'hC0, 8'hDF));
          else if ($urandom_range(0, 4) == 0) m = MarkerCom;
          else m = AppFirst + 8'($urandom_range(0, 15));
          if (m >= RstFirst && m <= MarkerEoi) m = 8'hDB;
          seg_len = 16'($urandom_range(2, 16));
          if ($urandom_range(0, 3) == 0 && limit_q <= 16'd40)
            seg_len = limit_q + 16'($urandom_range(0, 2));
          if (seg_len < LenHdrBytes) seg_len = LenHdrBytes;
          append_byte(FillByte);
          append_byte(m);
          append_byte(seg_len[15:8]);
          append_byte(seg_len[7:0]);
          for (int j = 0; j + 2 < int'(seg_len); j++)
            append_byte(8'($urandom_range(0, 255)));
        end
        5: begin
          // entropy data with stuffing, restarts and fill
          n = $urandom_range(1, 12);
          repeat (n) begin
            v = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 5) == 0) v = FillByte;
            append_byte(v);
            if (v == FillByte) begin
              case ($urandom_range(0, 2))
                0: append_byte(StuffByte);
                1: append_byte(RstFirst + 8'($urandom_range(0, 7)));
                default: begin
                  append_byte(FillByte);
                  append_byte(StuffByte);
                end
              endcase
            end
          end
        end
        6: begin
          // length below two ends the scan
          append_byte(FillByte);
          append_byte(($urandom_range(0, 1) != 0) ? MarkerApp1 : MarkerCom);
          append_byte(8'h00);
          append_byte(8'($urandom_range(0, 1)));
        end
        7: begin
          // long segment cut off by the end of file
          seg_len = 16'($urandom_range(16'h0100, 16'hFFFF));
          append_byte(FillByte);
          append_byte(($urandom_range(0, 3) == 0) ? MarkerCom
                      : AppFirst + 8'($urandom_range(0, 15)));
          append_byte(seg_len[15:8]);
          append_byte(seg_len[7:0]);
          repeat ($urandom_range(0, 6)) append_byte(8'($urandom_range(0, 255)));
          cut = 1'b1;
        end
        8: repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
        default: begin
          repeat ($urandom_range(2, 4)) append_byte(FillByte);
          append_byte(RstFirst + 8'($urandom_range(0, 7)));
        end
      endcase
    end
    if (!cut && $urandom_range(0, 4) != 0) begin
      append_byte(FillByte);
      append_byte(MarkerEoi);
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 5)) append_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0 && file_bytes.size() > 1) begin
      keep = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
  endtask

  initial begin : stim
    rpt_t        want;
    int unsigned ph_items, ph_files;
    logic [15:0] lim;
    byte_if.valid = 1'b0;
    byte_if.byte_value = '0;
    byte_if.last_byte = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.text_segment_limit = '0;
    rst_ni = 1'b0;
    limit_q = LimitReset;
    rearm_parser();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirCount; i++) begin
      want = '0;
      {want.bad_header, want.big_text_segment, want.bad_exif, want.trailing_data} =
          DirRows[i].flags;
      want.trailing_count = 32'(DirRows[i].count);
      want.anomaly = |DirRows[i].flags;
      put_byte(DirRows[i].value, DirRows[i].last, DirRows[i].typed, want);
    end

    for (int phase = 0; phase < 6; phase++) begin
      if (phase != 0) begin
        drain();
        case (phase)
          1: lim = 16'h0000;
          2: lim = 16'hFFFF;
          3: lim = 16'($urandom_range(2, 40));
          4: lim = 16'($urandom_range(0, 65535));
          default: lim = LimitReset;
        endcase
        write_limit(lim);
      end
      if (phase == 2) hold_off_req = 1'b1;
      ph_items = 0;
      ph_files = 0;
      while (ph_items < 110 || ph_files < 4) begin
        build_file();
        foreach (file_bytes[k])
          put_byte(file_bytes[k], k == file_bytes.size() - 1, 1'b0, '0);
        ph_items += file_bytes.size();
        ph_files++;
      end
    end

    drain();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
